/* rtl/rsst_pkg.sv */
`default_nettype none

package rsst_pkg;

  // Default number of leaves. It must be a power of two.
  localparam int LEAVES_DEF = 1024;

  // Fixed field widths of the request and result transactions.
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 10;
  localparam int RANGE_W = 11;

  // Command codes carried by a request transaction.
  typedef enum logic [0:0] {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } command_t;

  // One tree node sum.
  typedef logic [DATA_W-1:0] word_t;

endpackage

`default_nettype wire

/* rtl/rsst_if.sv */
`default_nettype none

// Request channel: one update or query command per transaction.
interface rsst_in_if import rsst_pkg::*;;
  logic                      valid;
  logic                      ready;
  command_t                  command;
  logic [INDEX_W-1:0]        leaf_index;
  logic signed [DATA_W-1:0]  new_value;
  logic [RANGE_W-1:0]        range_start;
  logic [RANGE_W-1:0]        range_end;

  modport source (
    output valid, command, leaf_index, new_value, range_start, range_end,
    input  ready
  );

  modport sink (
    input  valid, command, leaf_index, new_value, range_start, range_end,
    output ready
  );
endinterface

// Result channel: one range sum per query transaction.
interface rsst_out_if import rsst_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [DATA_W-1:0]  range_total;

  modport source (
    output valid, range_total,
    input  ready
  );

  modport sink (
    input  valid, range_total,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/range_sum_segment_tree.sv */
`default_nettype none

// Range-sum segment tree over LEAVES signed 32-bit leaves (LEAVES a power of
// two). An update transaction writes one leaf and rewrites its ancestors; an
// update whose leaf index is not below LEAVES is dropped. A query transaction
// returns one wrapped sum over the half-open leaf range [range_start,
// range_end), with both bounds clamped to LEAVES; an empty or reversed range
// returns zero. All node sums sit in one single-port memory with a registered
// read, and one shared 32-bit adder forms every sum, so the memory port sets
// the pace, and a request is taken only while no command is in progress.
// After reset the block clears all 2*LEAVES words of the memory one word a
// cycle and holds ready low meanwhile. A finished query result waits in an
// output register, and the next request is accepted while it waits.
module range_sum_segment_tree import rsst_pkg::*; #(
  parameter int LEAVES = LEAVES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rsst_in_if.sink     request,
  rsst_out_if.source  result
);

  localparam int LW = $clog2(LEAVES);
  localparam int AW = LW + 1;
  localparam int PW = LW + 2;
  localparam int CW = (PW > RANGE_W) ? PW : RANGE_W;
  localparam int IW = (PW > INDEX_W) ? PW : INDEX_W;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_U_LEAF,
    S_U_READ,
    S_U_WRITE,
    S_Q_LO,
    S_Q_HI,
    S_Q_SHIFT,
    S_Q_DONE
  } state_t;

  state_t        state;
  logic [AW-1:0] clr_addr;
  logic [PW-1:0] pos;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi;
  word_t         acc;
  logic          rd_pending;
  logic          out_valid;
  word_t         out_total;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  word_t         mem_wdata;
  word_t         mem_rdata;
  word_t         sum;

  logic [CW-1:0] start_w;
  logic [CW-1:0] end_w;
  logic [CW-1:0] lo_clamp;
  logic [CW-1:0] hi_clamp;
  logic          range_empty;
  logic [PW-1:0] lo_init;
  logic [PW-1:0] hi_init;
  logic [IW-1:0] idx_w;
  logic          leaf_ok;
  logic [PW-1:0] leaf_pos;

  rsst_ram #(
    .AW (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Decode of the incoming request: clamp the range and map to heap positions.
  always_comb begin
    start_w     = CW'(request.range_start);
    end_w       = CW'(request.range_end);
    lo_clamp    = (start_w > CW'(LEAVES)) ? CW'(LEAVES) : start_w;
    hi_clamp    = (end_w > CW'(LEAVES)) ? CW'(LEAVES) : end_w;
    range_empty = (lo_clamp >= hi_clamp);
    lo_init     = PW'(lo_clamp) + PW'(LEAVES);
    hi_init     = PW'(hi_clamp) + PW'(LEAVES);
    idx_w       = IW'(request.leaf_index);
    leaf_ok     = (idx_w < IW'(LEAVES));
    leaf_pos    = PW'(idx_w) + PW'(LEAVES);
  end

  // The one shared adder: running value plus the word just read.
  assign sum = acc + mem_rdata;

  // Memory port control for each sequencer step.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = acc;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = '0;
      end
      S_U_LEAF: begin
        mem_we   = 1'b1;
        mem_addr = AW'(pos);
      end
      S_U_READ: begin
        mem_addr = AW'(pos ^ PW'(1));
      end
      S_U_WRITE: begin
        mem_we    = 1'b1;
        mem_addr  = AW'(pos >> 1);
        mem_wdata = sum;
      end
      S_Q_LO: begin
        mem_addr = AW'(lo);
      end
      S_Q_HI: begin
        mem_addr = AW'(hi - PW'(1));
      end
      default: begin
        mem_addr = '0;
      end
    endcase
  end

  assign request.ready      = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.range_total = out_total;

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // A completing query reloads the output register on its own.
      if (out_valid && result.ready && (state != S_Q_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (request.valid) begin
            if (request.command == CMD_UPDATE) begin
              if (leaf_ok) begin
                pos   <= leaf_pos;
                acc   <= request.new_value;
                state <= S_U_LEAF;
              end
            end else begin
              acc   <= '0;
              lo    <= lo_init;
              hi    <= hi_init;
              state <= range_empty ? S_Q_DONE : S_Q_LO;
            end
          end
        end
        S_U_LEAF: begin
          state <= S_U_READ;
        end
        S_U_READ: begin
          // The root has been written once the position reaches one.
          if (pos == PW'(1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_U_WRITE;
          end
        end
        S_U_WRITE: begin
          acc   <= sum;
          pos   <= pos >> 1;
          state <= S_U_READ;
        end
        S_Q_LO: begin
          if (lo >= hi) begin
            rd_pending <= 1'b0;
            state      <= S_Q_DONE;
          end else begin
            rd_pending <= lo[0];
            if (lo[0]) begin
              lo <= lo + PW'(1);
            end
            state <= S_Q_HI;
          end
        end
        S_Q_HI: begin
          if (rd_pending) begin
            acc <= sum;
          end
          rd_pending <= hi[0];
          if (hi[0]) begin
            hi <= hi - PW'(1);
          end
          state <= S_Q_SHIFT;
        end
        S_Q_SHIFT: begin
          if (rd_pending) begin
            acc <= sum;
          end
          rd_pending <= 1'b0;
          lo         <= lo >> 1;
          hi         <= hi >> 1;
          state      <= S_Q_LO;
        end
        S_Q_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_total <= acc;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An accepted in-range update always starts by writing its leaf.
  a_update_start: assert property (@(posedge clk) disable iff (rst)
    (request.valid && request.ready && request.command == CMD_UPDATE && leaf_ok)
      |=> (state == S_U_LEAF))
    else $error("update did not start with the leaf write");

  // The query bounds never cross while the walk is in progress.
  a_query_bounds: assert property (@(posedge clk) disable iff (rst)
    ((state == S_Q_LO) || (state == S_Q_HI) || (state == S_Q_SHIFT)) |-> (lo <= hi))
    else $error("query bounds crossed");

  // A new result appears only when a query has finished.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_Q_DONE))
    else $error("result raised outside query completion");

  // No accumulation is left pending once the block is idle again.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !rd_pending)
    else $error("pending read left over in idle");

  // The ancestor walk never reaches position zero.
  a_update_pos: assert property (@(posedge clk) disable iff (rst)
    ((state == S_U_READ) || (state == S_U_WRITE)) |-> (pos != '0))
    else $error("update walked past the root");

endmodule

`default_nettype wire

/* rtl/rsst_ram.sv */
`default_nettype none

// Single-port node memory with a registered read. A read of the addressed
// word happens every cycle; its data is available in the following cycle.
module rsst_ram import rsst_pkg::*; #(
  parameter int AW = $clog2(LEAVES_DEF) + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  word_t         wdata,
  output word_t         rdata
);

  localparam int DEPTH = 2 ** AW;

  word_t mem [DEPTH];

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

/* bench/range_sum_segment_tree_tb.sv */
`timescale 1ns / 100ps

module range_sum_segment_tree_tb;
  import rsst_pkg::*;

  localparam int LEAVES           = LEAVES_DEF;
  localparam int N_DIRECTED       = 24;
  localparam int N_PHASES         = 4;
  localparam int RANDOM_PER_PHASE = 425;
  localparam int DRAIN_CYCLES     = 40;
  localparam int MAX_REPORTS      = 10;

  // One request transaction, plus an optional hand-typed expected sum.
  typedef struct {
    command_t            command;
    logic [INDEX_W-1:0]  leaf_index;
    word_t               new_value;
    logic [RANGE_W-1:0]  range_start;
    logic [RANGE_W-1:0]  range_end;
    bit                  pinned;
    word_t               pinned_total;
  } tree_op_t;

  // One range sum still owed by the block.
  typedef struct {
    word_t               total;
    logic [RANGE_W-1:0]  range_start;
    logic [RANGE_W-1:0]  range_end;
  } owed_sum_t;

  logic clk;
  logic rst;

  rsst_in_if  req_ch ();
  rsst_out_if res_ch ();

  range_sum_segment_tree #(.LEAVES(LEAVES)) uut (
    .clk     (clk),
    .rst     (rst),
    .request (req_ch),
    .result  (res_ch)
  );

  // Directed table: extremes, wraparound, clamping and empty or reversed ranges.
  tree_op_t directed_ops [N_DIRECTED] = '{
    // Fresh tree, full range, empty range, and both bounds clamped.
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd1024, 1'b1, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd0,    1'b1, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd1024, 11'd2047, 1'b1, 32'h0000_0000},
    // Extreme values at the two outermost leaves.
    '{CMD_UPDATE, 10'd0,    32'h7fff_ffff, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_UPDATE, 10'd1023, 32'h8000_0000, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd1,    1'b1, 32'h7fff_ffff},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd1023, 11'd1024, 1'b1, 32'h8000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd1024, 1'b1, 32'hffff_ffff},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd2047, 1'b1, 32'hffff_ffff},
    // Positive overflow wraps to the most negative value.
    '{CMD_UPDATE, 10'd1,    32'h0000_0001, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd2,    1'b1, 32'h8000_0000},
    // Reversed ranges give zero.
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd2,    11'd1,    1'b1, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd2047, 11'd0,    1'b1, 32'h0000_0000},
    // Interior ranges crossing the middle of the tree.
    '{CMD_UPDATE, 10'd512,  32'hffff_fffb, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd1,    11'd1023, 1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd511,  11'd513,  1'b0, 32'h0000_0000},
    // Overwrite a leaf, then sum everything.
    '{CMD_UPDATE, 10'd0,    32'h0000_0000, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd0,    11'd1024, 1'b0, 32'h0000_0000},
    '{CMD_UPDATE, 10'd1023, 32'hffff_ffff, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd1000, 11'd2000, 1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd1024, 11'd1024, 1'b1, 32'h0000_0000},
    '{CMD_UPDATE, 10'd700,  32'h5555_5555, 11'd0,    11'd0,    1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd700,  11'd701,  1'b0, 32'h0000_0000},
    '{CMD_QUERY,  10'd0,    32'h0000_0000, 11'd1,    11'd1024, 1'b0, 32'h0000_0000}
  };

  // Idle and stall percentages for each phase.
  int send_idle_by_phase [N_PHASES] = '{0, 59, 0, 12};
  int recv_stall_by_phase [N_PHASES] = '{0, 0, 59, 12};

  // Predicted tree, 1-based heap order: node n has children 2n and 2n+1.
  word_t tree_nodes [1:2*LEAVES-1];

  tree_op_t  pending_ops [$];
  owed_sum_t owed_sums [$];
  tree_op_t  cur_op;

  int send_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int update_count;
  int query_count;
  int sums_checked;

  // Write one leaf and recompute every ancestor up to the root.
  function automatic void tree_write(int unsigned idx, word_t value);
    int unsigned pos;
    if (idx >= LEAVES) return;
    pos = LEAVES + idx;
    tree_nodes[pos] = value;
    while (pos > 1) begin
      pos = pos >> 1;
      tree_nodes[pos] = tree_nodes[2*pos] + tree_nodes[2*pos+1];
    end
  endfunction

  // Wrapped sum over the clamped half-open range [lo, hi).
  function automatic word_t tree_range_sum(int unsigned lo, int unsigned hi);
    word_t acc;
    acc = '0;
    if (lo > LEAVES) lo = LEAVES;
    if (hi > LEAVES) hi = LEAVES;
    if (lo >= hi) return '0;
    lo += LEAVES;
    hi += LEAVES;
    while (lo < hi) begin
      if (lo[0]) begin
        acc += tree_nodes[lo];
        lo++;
      end
      if (hi[0]) begin
        hi--;
        acc += tree_nodes[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  // Random transaction: half updates, half queries, with edge-heavy content.
  function automatic tree_op_t random_op();
    tree_op_t op;
    int       kind;
    int       lo;
    op.command      = ($urandom_range(1) != 0) ? CMD_QUERY : CMD_UPDATE;
    op.leaf_index   = INDEX_W'($urandom_range(LEAVES - 1));
    op.new_value    = $urandom;
    op.range_start  = RANGE_W'($urandom_range(2047));
    op.range_end    = RANGE_W'($urandom_range(2047));
    op.pinned       = 1'b0;
    op.pinned_total = '0;
    if (op.command == CMD_UPDATE) begin
      kind = $urandom_range(7);
      if (kind == 0) op.leaf_index = INDEX_W'($urandom_range(7));
      else if (kind == 1) op.leaf_index = INDEX_W'($urandom_range(LEAVES - 1, LEAVES - 8));
      kind = $urandom_range(7);
      if (kind == 0) op.new_value = 32'h8000_0000;
      else if (kind == 1) op.new_value = 32'h7fff_ffff;
      else if (kind == 2) op.new_value = $urandom_range(200) - 100;
    end else begin
      kind = $urandom_range(9);
      if (kind <= 5) begin
        lo = $urandom_range(LEAVES);
        op.range_start = RANGE_W'(lo);
        op.range_end   = RANGE_W'($urandom_range(LEAVES, lo));
      end else if (kind == 6) begin
        lo = $urandom_range(LEAVES - 8);
        op.range_start = RANGE_W'(lo);
        op.range_end   = RANGE_W'(lo + $urandom_range(8));
      end else if (kind == 7) begin
        lo = $urandom_range(LEAVES);
        op.range_start = RANGE_W'(lo);
        op.range_end   = RANGE_W'($urandom_range(lo));
      end
    end
    return op;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  // Clock.
  always #5 clk = ~clk;

  // Request side: account for the accepted transaction, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        if (cur_op.command == CMD_UPDATE) begin
          update_count++;
          tree_write(cur_op.leaf_index, cur_op.new_value);
        end else begin
          query_count++;
          owed_sums.push_back(owed_sum_t'{
            cur_op.pinned ? cur_op.pinned_total
                          : tree_range_sum(cur_op.range_start, cur_op.range_end),
            cur_op.range_start, cur_op.range_end});
        end
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op = pending_ops.pop_front();
          req_ch.valid       <= 1'b1;
          req_ch.command     <= cur_op.command;
          req_ch.leaf_index  <= cur_op.leaf_index;
          req_ch.new_value   <= cur_op.new_value;
          req_ch.range_start <= cur_op.range_start;
          req_ch.range_end   <= cur_op.range_end;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stalls, and each accepted sum checked against the oldest owed one.
  always @(posedge clk) begin
    owed_sum_t owed;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (res_ch.valid && res_ch.ready) begin
        if (owed_sums.size() == 0) begin
          note_mismatch($sformatf("unexpected result transaction, range_total=%h",
                                  res_ch.range_total));
        end else begin
          owed = owed_sums.pop_front();
          sums_checked++;
          if (res_ch.range_total !== owed.total)
            note_mismatch($sformatf("sum [%0d,%0d): expected %h, got %h",
                                    owed.range_start, owed.range_end, owed.total,
                                    res_ch.range_total));
        end
      end
    end
  end

  // Run limit.
  initial begin
    #(5_000_000);
    $display("range_sum_segment_tree_tb: FAIL");
    $finish;
  end

  // Main sequence: reset, then the directed table and the random phases.
  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.command     = CMD_UPDATE;
    req_ch.leaf_index  = '0;
    req_ch.new_value   = '0;
    req_ch.range_start = '0;
    req_ch.range_end   = '0;
    res_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    mismatch_count     = 0;
    update_count       = 0;
    query_count        = 0;
    sums_checked       = 0;
    foreach (tree_nodes[n]) tree_nodes[n] = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < N_PHASES; phase++) begin
      @(negedge clk);
      send_idle_pct  = send_idle_by_phase[phase];
      recv_stall_pct = recv_stall_by_phase[phase];
      if (phase == 0) begin
        for (int r = 0; r < N_DIRECTED; r++) pending_ops.push_back(directed_ops[r]);
      end
      for (int k = 0; k < RANDOM_PER_PHASE; k++) pending_ops.push_back(random_op());
      // Wait until every transaction of this phase is in and every sum is out.
      while (pending_ops.size() != 0 || req_ch.valid || owed_sums.size() != 0)
        @(negedge clk);
    end

    // Give a trailing update time to finish and any stray result time to show.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (owed_sums.size() != 0)
      note_mismatch($sformatf("%0d range sums never arrived", owed_sums.size()));

    $display("summary: %0d updates and %0d queries accepted, %0d range sums checked,",
             update_count, query_count, sums_checked);
    $display("summary: %0d mismatches over %0d idle/stall phases", mismatch_count, N_PHASES);
    if (mismatch_count == 0) begin
      $display("range_sum_segment_tree_tb: PASS");
    end else begin
      $display("range_sum_segment_tree_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rsst_pkg.sv
rtl/rsst_if.sv
rtl/rsst_ram.sv
rtl/range_sum_segment_tree.sv
bench/range_sum_segment_tree_tb.sv
